// ----- hdl/fcr_pkg.sv -----
`timescale 1ns / 1ps

package fcr_pkg;

  // default body store depth, first body byte up to the last checksum byte
  localparam int BodyDepth = 32;

  // header bytes
  localparam logic [7:0] HdrG = 8'h47;
  localparam logic [7:0] HdrB = 8'h42;
  localparam logic [15:0] HdrSum = 16'h0089;

  // configuration reset values
  localparam logic [7:0]  OwnAddrRst = 8'h02;
  localparam logic [7:0]  PeerAddrRst = 8'h01;
  localparam logic [15:0] TimeoutRst = 16'd100;

  // configuration register indexes
  localparam logic [1:0] CfgOwnAddr = 2'd0;
  localparam logic [1:0] CfgPeerAddr = 2'd1;
  localparam logic [1:0] CfgTimeout = 2'd2;

  // shortest legal length byte: id plus two checksum bytes
  localparam logic [7:0] MinLen = 8'd3;
  localparam logic [7:0] IdCount = 8'd19;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_CHK = 3'd1,
    ST_SHORT   = 3'd2,
    ST_BAD_ID  = 3'd3,
    ST_BAD_LEN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_GOT_G = 3'd1,
    PH_DEST = 3'd2,
    PH_SRC  = 3'd3,
    PH_SEQ  = 3'd4,
    PH_LEN  = 3'd5,
    PH_BODY = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_READ = 2'd1,
    EM_HOLD = 2'd2
  } emit_state_e;

  // result job handed from the parser to the emitter
  typedef struct packed {
    logic       start;
    logic       single;
    status_e    status;
    logic [7:0] msg_id;
    logic [7:0] seq;
    logic [7:0] plen;
  } job_t;

  // minimum payload length per message id
  function automatic logic [7:0] min_payload(input logic [7:0] id);
    logic [7:0] r;
    case (id)
      8'd0:  r = 8'd0;
      8'd1, 8'd2, 8'd3, 8'd5, 8'd9, 8'd17: r = 8'd1;
      8'd4, 8'd15, 8'd16: r = 8'd2;
      8'd6, 8'd7, 8'd18: r = 8'd5;
      8'd8:  r = 8'd9;
      8'd10, 8'd11, 8'd12, 8'd13, 8'd14: r = 8'd6;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/fcr_body_mem.sv -----
`timescale 1ns / 1ps

module fcr_body_mem #(
  parameter int DEPTH = fcr_pkg::BodyDepth,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/fcr_parser.sv -----
`timescale 1ns / 1ps

module fcr_parser #(
  parameter int BODY_DEPTH = fcr_pkg::BodyDepth,
  parameter int AW = $clog2(BODY_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          tick_i,
  input  logic [7:0]    byte_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o,
  output fcr_pkg::job_t job_o
);

  localparam logic [7:0] DepthB = 8'(BODY_DEPTH);

  fcr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] idle_q, idle_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  own_q, peer_q;
  logic [15:0] tmo_q;

  logic [15:0] sum_add;
  logic [15:0] idle_inc;
  logic [15:0] chk;
  logic [7:0]  fin_id;
  logic [7:0]  plen;
  logic        len_bad;
  logic        body_end;
  fcr_pkg::phase_e rehunt;

  assign sum_add  = sum_q + {8'd0, byte_i};
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign chk      = ~sum_q;
  assign fin_id   = (count_q == 8'd0) ? byte_i : id_q;
  assign plen     = len_q - fcr_pkg::MinLen;
  assign rehunt   = (byte_i == fcr_pkg::HdrG) ? fcr_pkg::PH_GOT_G : fcr_pkg::PH_HUNT;
  assign len_bad  = (byte_i < fcr_pkg::MinLen) || (byte_i > DepthB);
  assign body_end = ({1'b0, count_q} + 9'd1 >= {1'b0, len_q});

  assign wr_en_o   = accept_i && !tick_i && (phase_q == fcr_pkg::PH_BODY);
  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = byte_i;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    seq_d   = seq_q;
    sum_d   = sum_q;
    idle_d  = idle_q;
    id_d    = id_q;
    prev_d  = prev_q;
    if (accept_i && tick_i) begin
      if (phase_q == fcr_pkg::PH_DEST || phase_q == fcr_pkg::PH_SRC ||
          phase_q == fcr_pkg::PH_SEQ || phase_q == fcr_pkg::PH_LEN ||
          phase_q == fcr_pkg::PH_BODY) begin
        if (idle_inc >= tmo_q) begin
          phase_d = fcr_pkg::PH_HUNT;
          count_d = 8'd0;
          idle_d  = 16'd0;
        end else begin
          idle_d = idle_inc;
        end
      end
    end else if (accept_i) begin
      idle_d = 16'd0;
      unique case (phase_q)
        fcr_pkg::PH_HUNT: phase_d = rehunt;
        fcr_pkg::PH_GOT_G: begin
          if (byte_i == fcr_pkg::HdrB) begin
            sum_d   = fcr_pkg::HdrSum;
            phase_d = fcr_pkg::PH_DEST;
          end else begin
            phase_d = rehunt;
          end
        end
        fcr_pkg::PH_DEST: begin
          if (byte_i == own_q) begin
            sum_d   = sum_add;
            phase_d = fcr_pkg::PH_SRC;
          end else begin
            phase_d = rehunt;
          end
        end
        fcr_pkg::PH_SRC: begin
          if (byte_i == peer_q) begin
            sum_d   = sum_add;
            phase_d = fcr_pkg::PH_SEQ;
          end else begin
            phase_d = rehunt;
          end
        end
        fcr_pkg::PH_SEQ: begin
          seq_d   = byte_i;
          sum_d   = sum_add;
          phase_d = fcr_pkg::PH_LEN;
        end
        fcr_pkg::PH_LEN: begin
          sum_d = sum_add;
          if (len_bad) begin
            phase_d = fcr_pkg::PH_HUNT;
          end else begin
            len_d   = byte_i;
            count_d = 8'd0;
            phase_d = fcr_pkg::PH_BODY;
          end
        end
        fcr_pkg::PH_BODY: begin
          prev_d = byte_i;
          if (count_q == 8'd0) begin
            id_d = byte_i;
          end
          if ({1'b0, count_q} + 9'd2 < {1'b0, len_q}) begin
            sum_d = sum_add;
          end
          count_d = count_q + 8'd1;
          if (body_end) begin
            count_d = 8'd0;
            phase_d = fcr_pkg::PH_HUNT;
          end
        end
        default: phase_d = rehunt;
      endcase
    end
  end

  always_comb begin
    job_o        = '0;
    job_o.status = fcr_pkg::ST_OK;
    job_o.seq    = seq_q;
    if (accept_i && !tick_i) begin
      if (phase_q == fcr_pkg::PH_LEN && len_bad) begin
        job_o.start  = 1'b1;
        job_o.single = 1'b1;
        job_o.status = fcr_pkg::ST_BAD_LEN;
      end else if (phase_q == fcr_pkg::PH_BODY && body_end) begin
        // end of body: checksum, then id range, then minimum payload
        job_o.start  = 1'b1;
        job_o.msg_id = fin_id;
        job_o.plen   = plen;
        if (prev_q != chk[15:8] || byte_i != chk[7:0]) begin
          job_o.status = fcr_pkg::ST_BAD_CHK;
        end else if (fin_id >= fcr_pkg::IdCount) begin
          job_o.status = fcr_pkg::ST_BAD_ID;
        end else if (fcr_pkg::min_payload(fin_id) > plen) begin
          job_o.status = fcr_pkg::ST_SHORT;
        end
        job_o.single = (job_o.status != fcr_pkg::ST_OK) || (plen == 8'd0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fcr_pkg::PH_HUNT;
      count_q <= 8'd0;
      len_q   <= 8'd0;
      seq_q   <= 8'd0;
      sum_q   <= 16'd0;
      idle_q  <= 16'd0;
      id_q    <= 8'd0;
      prev_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      seq_q   <= seq_d;
      sum_q   <= sum_d;
      idle_q  <= idle_d;
      id_q    <= id_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q  <= fcr_pkg::OwnAddrRst;
      peer_q <= fcr_pkg::PeerAddrRst;
      tmo_q  <= fcr_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fcr_pkg::CfgOwnAddr:  own_q  <= cfg_data_i[7:0];
        fcr_pkg::CfgPeerAddr: peer_q <= cfg_data_i[7:0];
        fcr_pkg::CfgTimeout:  tmo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/fcr_emitter.sv -----
`timescale 1ns / 1ps

module fcr_emitter #(
  parameter int BODY_DEPTH = fcr_pkg::BodyDepth,
  parameter int AW = $clog2(BODY_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fcr_pkg::job_t job_i,
  output logic          busy_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  logic [7:0]    rd_data_i,
  output logic          tvalid_o,
  input  logic          tready_i,
  output logic [31:0]   tdata_o,
  output logic          tuser_o,
  output logic          tlast_o
);

  fcr_pkg::emit_state_e state_q, state_d;
  logic            single_q;
  fcr_pkg::status_e status_q;
  logic [7:0]      id_q, seq_q, plen_q, idx_q;
  logic [7:0]      rd_idx;
  logic            is_last;
  logic [7:0]      payload;

  // payload byte i sits after the message id
  assign rd_idx  = idx_q + 8'd1;
  assign is_last = single_q || (rd_idx == plen_q);
  assign payload = single_q ? 8'd0 : rd_data_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcr_pkg::EM_IDLE: begin
        if (job_i.start) begin
          state_d = job_i.single ? fcr_pkg::EM_HOLD : fcr_pkg::EM_READ;
        end
      end
      fcr_pkg::EM_READ: state_d = fcr_pkg::EM_HOLD;
      fcr_pkg::EM_HOLD: begin
        if (tready_i) begin
          state_d = is_last ? fcr_pkg::EM_IDLE : fcr_pkg::EM_READ;
        end
      end
      default: state_d = fcr_pkg::EM_IDLE;
    endcase
  end

  always_comb begin
    busy_o    = (state_q != fcr_pkg::EM_IDLE);
    rd_en_o   = (state_q == fcr_pkg::EM_READ);
    rd_addr_o = rd_idx[AW-1:0];
    tvalid_o  = (state_q == fcr_pkg::EM_HOLD);
    tdata_o   = {5'd0, payload, seq_q, id_q, status_q};
    tuser_o   = !single_q;
    tlast_o   = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcr_pkg::EM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fcr_pkg::EM_IDLE && job_i.start) begin
      single_q <= job_i.single;
      status_q <= job_i.status;
      id_q     <= job_i.msg_id;
      seq_q    <= job_i.seq;
      plen_q   <= job_i.plen;
      idx_q    <= 8'd0;
    end else if (state_q == fcr_pkg::EM_HOLD && tready_i && !is_last) begin
      idx_q <= rd_idx;
    end
  end

endmodule

// ----- hdl/framed_command_receiver.sv -----
`timescale 1ns / 1ps
// timing: a single status result is offered in the cycle after the last body byte; a payload
// result first passes the emitter READ state, which reads body memory, and is offered in HOLD
// throughput: one input request per cycle while no results are pending
// results: each payload byte is read in READ; the next is read only once HOLD's result is taken
// input is held off until every result of a frame has been taken downstream
// reset: asynchronous active low; parser hunts for the header, registers return to defaults

module framed_command_receiver #(
  parameter int BODY_DEPTH = fcr_pkg::BodyDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] mode (1 = timer tick)
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] status, [10:3] message_id,
                                      // [18:11] sequence_res, [26:19] payload_byte
  output logic        m_axis_tuser,   // [0] byte_valid
  output logic        m_axis_tlast,   // last result of the frame
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int AW = $clog2(BODY_DEPTH);

  logic          accept;
  logic          emit_busy;
  fcr_pkg::job_t job;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // the parser never stalls; only the emitter holds off requests
  assign s_axis_tready = !emit_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // header hunt, address check, running sum, idle timeout, body store writes and result jobs
  fcr_parser #(
    .BODY_DEPTH (BODY_DEPTH),
    .AW         (AW)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .tick_i     (s_axis_tuser),
    .byte_i     (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .job_o      (job)
  );

  // body bytes of the current frame; writes and reads never overlap in time
  fcr_body_mem #(
    .DEPTH (BODY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // walks the payload out of memory, or sends the single status result
  fcr_emitter #(
    .BODY_DEPTH (BODY_DEPTH),
    .AW         (AW)
  ) u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job),
    .busy_o    (emit_busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .tvalid_o  (m_axis_tvalid),
    .tready_i  (m_axis_tready),
    .tdata_o   (m_axis_tdata),
    .tuser_o   (m_axis_tuser),
    .tlast_o   (m_axis_tlast)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  // run limit in clock cycles, far above the slowest correct run
  localparam int CycleLimit = 300000;
  // cycles allowed for the block to settle once the last result is out
  localparam int SettleCycles = 20;
  // minimum payload per message id, id 0 in the lowest byte
  localparam logic [fcr_pkg::IdCount*8-1:0] MinPayloadTab = {
    8'd5, 8'd1, 8'd2, 8'd2, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd1,
    8'd9, 8'd5, 8'd5, 8'd1, 8'd2, 8'd1, 8'd1, 8'd1, 8'd0
  };

  // one request: a received byte or a timer tick
  typedef struct packed {
    logic       tick;
    logic [7:0] data;
  } rx_req_t;

  // one result of a frame, as the block should send it
  typedef struct packed {
    fcr_pkg::status_e status;
    logic [7:0]       msg_id;
    logic [7:0]       seq;
    logic [7:0]       payload;
    logic             byte_valid;
    logic             last;
  } cmd_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  // request side, driven on the falling edge
  logic        in_valid = 1'b0;
  logic        in_tick = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        s_axis_tready;
  // result side
  logic        m_axis_tvalid;
  logic        rcv_ready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  // register writes
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = fcr_pkg::CfgOwnAddr;
  logic [15:0] cfg_data_i = 16'h0000;

  // stimulus and scoreboard
  rx_req_t     rx_pending[$];
  cmd_result_t cmd_results_due[$];
  int          items_queued = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 34;
  int          rcv_idle_pct = 83;
  int          rcv_hold_cycles = 0;
  logic        req_accepted = 1'b0;

  // register values as last written, used by stimulus and prediction
  logic [7:0]  cfg_own = fcr_pkg::OwnAddrRst;
  logic [7:0]  cfg_peer = fcr_pkg::PeerAddrRst;
  logic [15:0] cfg_tmo = fcr_pkg::TimeoutRst;

  // parser state of the predictor
  fcr_pkg::phase_e p_phase = fcr_pkg::PH_HUNT;
  logic [7:0]  p_body_cnt = 8'd0;
  logic [7:0]  p_body_len = 8'd0;
  logic [7:0]  p_seq = 8'd0;
  logic [15:0] p_sum = 16'd0;
  logic [7:0]  p_store [fcr_pkg::BodyDepth];
  logic [15:0] p_idle = 16'd0;

  always #5 clk_i = ~clk_i;

  framed_command_receiver uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_byte),      // [7:0] rx_byte
    .s_axis_tuser  (in_tick),      // [0] mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rcv_ready),
    .m_axis_tdata  (m_axis_tdata), // [2:0] status, [10:3] message_id,
                                   // [18:11] sequence_res, [26:19] payload_byte
    .m_axis_tuser  (m_axis_tuser), // [0] byte_valid
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // append one expected result, sequence byte taken from the parser state
  task automatic add_result(input fcr_pkg::status_e st, input logic [7:0] id,
                            input logic [7:0] pb, input logic bv, input logic lst);
    cmd_result_t r;
    r.status = st;
    r.msg_id = id;
    r.seq = p_seq;
    r.payload = pb;
    r.byte_valid = bv;
    r.last = lst;
    cmd_results_due.push_back(r);
  endtask

  // advance the frame parser by one accepted request
  task automatic parse_rx_request(input logic tick, input logic [7:0] b);
    logic [15:0] chk;
    logic [7:0]  id;
    int          plen;
    int          i;
    if (tick) begin
      // ticks only count once a full header has been seen
      if (p_phase >= fcr_pkg::PH_DEST && p_phase <= fcr_pkg::PH_BODY) begin
        if (p_idle != 16'hFFFF) p_idle = p_idle + 16'd1;
        if (p_idle >= cfg_tmo) begin
          p_phase = fcr_pkg::PH_HUNT;
          p_body_cnt = 8'd0;
          p_idle = 16'd0;
        end
      end
      return;
    end
    p_idle = 16'd0;
    case (p_phase)
      fcr_pkg::PH_GOT_G: begin
        if (b == fcr_pkg::HdrB) begin
          p_sum = fcr_pkg::HdrSum;
          p_phase = fcr_pkg::PH_DEST;
        end else begin
          p_phase = (b == fcr_pkg::HdrG) ? fcr_pkg::PH_GOT_G : fcr_pkg::PH_HUNT;
        end
      end
      fcr_pkg::PH_DEST: begin
        if (b == cfg_own) begin
          p_sum = p_sum + {8'd0, b};
          p_phase = fcr_pkg::PH_SRC;
        end else begin
          p_phase = (b == fcr_pkg::HdrG) ? fcr_pkg::PH_GOT_G : fcr_pkg::PH_HUNT;
        end
      end
      fcr_pkg::PH_SRC: begin
        if (b == cfg_peer) begin
          p_sum = p_sum + {8'd0, b};
          p_phase = fcr_pkg::PH_SEQ;
        end else begin
          p_phase = (b == fcr_pkg::HdrG) ? fcr_pkg::PH_GOT_G : fcr_pkg::PH_HUNT;
        end
      end
      fcr_pkg::PH_SEQ: begin
        p_seq = b;
        p_sum = p_sum + {8'd0, b};
        p_phase = fcr_pkg::PH_LEN;
      end
      fcr_pkg::PH_LEN: begin
        p_sum = p_sum + {8'd0, b};
        if (b < fcr_pkg::MinLen || int'(b) > fcr_pkg::BodyDepth) begin
          p_phase = fcr_pkg::PH_HUNT;
          add_result(fcr_pkg::ST_BAD_LEN, 8'd0, 8'd0, 1'b0, 1'b1);
        end else begin
          p_body_len = b;
          p_body_cnt = 8'd0;
          p_phase = fcr_pkg::PH_BODY;
        end
      end
      fcr_pkg::PH_BODY: begin
        if (int'(p_body_cnt) < fcr_pkg::BodyDepth) p_store[p_body_cnt] = b;
        // the two checksum bytes stay out of the sum
        if (int'(p_body_cnt) + 2 < int'(p_body_len)) p_sum = p_sum + {8'd0, b};
        p_body_cnt = p_body_cnt + 8'd1;
        if (p_body_cnt >= p_body_len) begin
          p_body_cnt = 8'd0;
          p_phase = fcr_pkg::PH_HUNT;
          chk = ~p_sum;
          id = p_store[0];
          plen = int'(p_body_len) - 3;
          // checksum first, then id range, then minimum payload
          if (p_store[p_body_len - 8'd2] != chk[15:8] ||
              p_store[p_body_len - 8'd1] != chk[7:0]) begin
            add_result(fcr_pkg::ST_BAD_CHK, id, 8'd0, 1'b0, 1'b1);
          end else if (id >= fcr_pkg::IdCount) begin
            add_result(fcr_pkg::ST_BAD_ID, id, 8'd0, 1'b0, 1'b1);
          end else if (int'(MinPayloadTab[id*8 +: 8]) > plen) begin
            add_result(fcr_pkg::ST_SHORT, id, 8'd0, 1'b0, 1'b1);
          end else if (plen == 0) begin
            add_result(fcr_pkg::ST_OK, id, 8'd0, 1'b0, 1'b1);
          end else begin
            for (i = 0; i < plen; i++)
              add_result(fcr_pkg::ST_OK, id, p_store[i+1], 1'b1, (i + 1 == plen));
          end
        end
      end
      default: p_phase = (b == fcr_pkg::HdrG) ? fcr_pkg::PH_GOT_G : fcr_pkg::PH_HUNT;
    endcase
  endtask

  // request driver: holds a request until taken, random gaps between requests
  always @(negedge clk_i) begin : rx_driver
    rx_req_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (req_accepted || !in_valid) begin
      req_accepted = 1'b0;
      if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = rx_pending.pop_front();
        in_valid <= 1'b1;
        in_tick <= nxt.tick;
        in_byte <= nxt.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (rcv_hold_cycles > 0) begin
      rcv_hold_cycles = rcv_hold_cycles - 1;
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk_i) begin : monitor
    cmd_result_t want;
    if (rst_ni) begin
      if (in_valid && s_axis_tready) begin
        parse_rx_request(in_tick, in_byte);
        req_accepted = 1'b1;
      end
      if (m_axis_tvalid && rcv_ready) begin
        if (cmd_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: tdata %h byte_valid %b last %b",
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = cmd_results_due.pop_front();
          if ({m_axis_tdata, m_axis_tuser, m_axis_tlast} !==
              {5'd0, want.payload, want.seq, want.msg_id, want.status,
               want.byte_valid, want.last}) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch: expected status %0d id %h seq %h byte %h valid %b last %b",
                       want.status, want.msg_id, want.seq, want.payload,
                       want.byte_valid, want.last);
              $display("  got status %0d id %h seq %h byte %h valid %b last %b pad %h",
                       m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[18:11],
                       m_axis_tdata[26:19], m_axis_tuser, m_axis_tlast,
                       m_axis_tdata[31:27]);
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic queue_req(input logic tick, input logic [7:0] b);
    rx_req_t r;
    r.tick = tick;
    r.data = b;
    rx_pending.push_back(r);
    items_queued++;
  endtask

  // frame byte, sometimes preceded by a short burst of ticks
  task automatic frame_byte(input logic [7:0] b, input int tick_pct);
    if ($urandom_range(99) < tick_pct)
      repeat ($urandom_range(1, 3)) queue_req(1'b1, 8'($urandom_range(255)));
    queue_req(1'b0, b);
  endtask

  // full frame; a length out of range sends only the bytes up to the length byte
  task automatic send_frame(input logic [7:0] dst, input logic [7:0] src,
                            input logic [7:0] sq, input logic [7:0] ln,
                            input logic [7:0] id, input logic bad_chk,
                            input int tick_pct);
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  pb;
    int          i;
    sum = fcr_pkg::HdrSum + {8'd0, dst} + {8'd0, src} + {8'd0, sq} + {8'd0, ln};
    frame_byte(fcr_pkg::HdrG, tick_pct);
    frame_byte(fcr_pkg::HdrB, tick_pct);
    frame_byte(dst, tick_pct);
    frame_byte(src, tick_pct);
    frame_byte(sq, tick_pct);
    frame_byte(ln, tick_pct);
    if (ln >= fcr_pkg::MinLen && int'(ln) <= fcr_pkg::BodyDepth) begin
      sum = sum + {8'd0, id};
      frame_byte(id, tick_pct);
      for (i = 0; i < int'(ln) - 3; i++) begin
        pb = 8'($urandom_range(255));
        sum = sum + {8'd0, pb};
        frame_byte(pb, tick_pct);
      end
      chk = ~sum;
      // corrupt the checksum with a nonzero pattern
      if (bad_chk) chk = chk ^ 16'($urandom_range(1, 65535));
      frame_byte(chk[15:8], tick_pct);
      frame_byte(chk[7:0], tick_pct);
    end
  endtask

  // mostly well-formed frames with random content, the rest noise and breakage
  task automatic random_traffic(input int count, input int tick_pct);
    int         goal;
    int         kind;
    int         plen;
    logic [7:0] id;
    goal = items_queued + count;
    while (items_queued < goal) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        id = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(18));
        plen = ($urandom_range(9) == 0) ? $urandom_range(29) : $urandom_range(10);
        send_frame(cfg_own, cfg_peer, 8'($urandom_range(255)), 8'(plen + 3), id,
                   ($urandom_range(6) == 0), tick_pct);
      end else if (kind < 75) begin
        // length below the minimum or above the store
        send_frame(cfg_own, cfg_peer, 8'($urandom_range(255)),
                   $urandom_range(1) ? 8'($urandom_range(2)) : 8'($urandom_range(255, 33)),
                   8'd0, 1'b0, tick_pct);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4))
          queue_req(1'($urandom_range(1)),
                    ($urandom_range(3) == 0) ? fcr_pkg::HdrG : 8'($urandom_range(255)));
      end else if (kind < 93) begin
        // header with a wrong address
        queue_req(1'b0, fcr_pkg::HdrG);
        queue_req(1'b0, fcr_pkg::HdrB);
        if ($urandom_range(1)) begin
          queue_req(1'b0, cfg_own ^ 8'($urandom_range(1, 255)));
        end else begin
          queue_req(1'b0, cfg_own);
          queue_req(1'b0, cfg_peer ^ 8'($urandom_range(1, 255)));
        end
      end else begin
        // partial frame, followed by enough ticks to time out when the timeout is 16 or less
        queue_req(1'b0, fcr_pkg::HdrG);
        queue_req(1'b0, fcr_pkg::HdrB);
        queue_req(1'b0, cfg_own);
        if ($urandom_range(1)) queue_req(1'b0, cfg_peer);
        if (cfg_tmo <= 16) repeat (cfg_tmo) queue_req(1'b1, 8'($urandom_range(255)));
      end
    end
  endtask

  // wait until every request is taken and every result is back, then settle
  task automatic wait_drained();
    while (rx_pending.size() != 0 || in_valid) @(posedge clk_i);
    while (cmd_results_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      fcr_pkg::CfgOwnAddr:  cfg_own = val[7:0];
      fcr_pkg::CfgPeerAddr: cfg_peer = val[7:0];
      fcr_pkg::CfgTimeout:  cfg_tmo = val;
      default: ;
    endcase
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tick while hunting, header restarts, bad lengths, empty payload
    queue_req(1'b1, 8'hFF);
    queue_req(1'b0, fcr_pkg::HdrG);
    queue_req(1'b0, fcr_pkg::HdrG);
    queue_req(1'b0, fcr_pkg::HdrB);
    queue_req(1'b0, cfg_own);
    queue_req(1'b0, fcr_pkg::HdrG);   // source mismatch that starts a new header
    queue_req(1'b0, fcr_pkg::HdrB);
    queue_req(1'b0, cfg_own);
    queue_req(1'b0, cfg_peer);
    queue_req(1'b0, 8'hFF);
    queue_req(1'b0, 8'h02);  // length below minimum
    send_frame(cfg_own, cfg_peer, 8'h00, fcr_pkg::MinLen, 8'h00, 1'b0, 0);
    send_frame(cfg_own, cfg_peer, 8'h00, 8'(fcr_pkg::BodyDepth + 1), 8'h00, 1'b0, 0);
    wait_drained();

    // slow sender, slower receiver, address extremes, longest timeout
    send_idle_pct = 34;
    rcv_idle_pct = 83;
    write_reg(fcr_pkg::CfgOwnAddr, 16'h0000);
    write_reg(fcr_pkg::CfgPeerAddr, 16'h00FF);
    write_reg(fcr_pkg::CfgTimeout, 16'hFFFF);
    random_traffic(55, 15);
    // sender pauses until every result has come back
    wait_drained();
    random_traffic(55, 15);
    wait_drained();

    // roles swapped, timeout of one tick
    send_idle_pct = 83;
    rcv_idle_pct = 34;
    write_reg(fcr_pkg::CfgOwnAddr, 16'h00FF);
    write_reg(fcr_pkg::CfgPeerAddr, 16'h0000);
    write_reg(fcr_pkg::CfgTimeout, 16'h0001);
    random_traffic(110, 5);
    wait_drained();

    // no idling, random addresses, small timeout, long receiver hold-off
    send_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(fcr_pkg::CfgOwnAddr, 16'($urandom_range(255)));
    write_reg(fcr_pkg::CfgPeerAddr, 16'($urandom_range(255)));
    write_reg(fcr_pkg::CfgTimeout, 16'($urandom_range(2, 6)));
    random_traffic(110, 10);
    rcv_hold_cycles = 400;
    wait_drained();

    if (fail_count == 0 && cmd_results_due.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fcr_pkg.sv
hdl/fcr_body_mem.sv
hdl/fcr_parser.sv
hdl/fcr_emitter.sv
hdl/framed_command_receiver.sv
tb/testbench.sv
